@@ hdl/sfb_pkg.sv @@
package sfb_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STATE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int WEIGHT_W = 17;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [STATE_W-1:0]  state_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      CSR_SMOOTHING_WEIGHT = 1'b0,
      CSR_STREAM_ENABLE    = 1'b1
   } csr_index_type;

   // Update command shared by the window cells and the smoother.
   typedef struct packed {
      logic fill;    // preload with the warm-up sample
      logic shift;   // take one new sample
   } state_ctl_type;

endpackage

@@ hdl/sfb_req_if.sv @@
interface sfb_req_if;
   import sfb_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       warm_up;

   modport source (output valid, output sample, output warm_up, input ready);
   modport sink (input valid, input sample, input warm_up, output ready);

endinterface

@@ hdl/sfb_rsp_if.sv @@
interface sfb_rsp_if;
   import sfb_pkg::*;

   logic       valid;
   logic       ready;
   sample_type raw_value;
   sample_type window_mean;
   sample_type window_median;
   sample_type smoothed;

   modport source (output valid, output raw_value, output window_mean,
                   output window_median, output smoothed, input ready);
   modport sink (input valid, input raw_value, input window_mean,
                 input window_median, input smoothed, output ready);

endinterface

@@ hdl/sfb_cell.sv @@
module sfb_cell #(
   parameter int WINDOW = 5,
   parameter int POS    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfb_pkg::state_ctl_type ctl,
   input  sfb_pkg::sample_type   fill_value,
   input  sfb_pkg::sample_type   neighbor_value,
   input  sfb_pkg::sample_type   window [WINDOW],
   output sfb_pkg::sample_type   value,
   output logic                  is_median
);
   import sfb_pkg::*;

   localparam int RANK_W = $clog2(WINDOW);

   sample_type        value_ff;
   sample_type        value_in;
   logic [RANK_W-1:0] rank;

   always_comb begin
      if (ctl.fill) begin
         value_in = fill_value;
      end else if (ctl.shift) begin
         value_in = neighbor_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   // Rank of this entry in the sorted window. Equal values are ordered by
   // position, so the ranks of all cells form a permutation.
   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if (j != POS) begin
            if ((window[j] < value_ff) || ((j < POS) && (window[j] == value_ff))) begin
               rank = rank + RANK_W'(1);
            end
         end
      end
   end

   assign value     = value_ff;
   assign is_median = (rank == RANK_W'(WINDOW / 2));

endmodule

@@ hdl/sfb_smoother.sv @@
module sfb_smoother (
   input  logic                   clock,
   input  logic                   reset,
   input  sfb_pkg::state_ctl_type ctl,
   input  sfb_pkg::sample_type    sample,
   input  sfb_pkg::weight_type    weight,
   output sfb_pkg::state_type     state
);
   import sfb_pkg::*;

   state_type                 state_ff;
   state_type                 state_in;
   logic signed [STATE_W:0]   diff;
   logic signed [STATE_W+WEIGHT_W+1:0] prod;

   // s' = s + floor(w * (v * 2^16 - s) / 2^16); the arithmetic shift floors.
   assign diff = {sample[SAMPLE_W-1], sample, {FRAC_W{1'b0}}}
               - {state_ff[STATE_W-1], state_ff};
   assign prod = $signed({1'b0, weight}) * diff;

   always_comb begin
      if (ctl.fill) begin
         state_in = {sample, {FRAC_W{1'b0}}};
      end else if (ctl.shift) begin
         state_in = state_ff + prod[FRAC_W +: STATE_W];
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

@@ hdl/sensor_filter_bank.sv @@
// Channel   Role    Payload                                             Handshake
// req_chan  sink    sample, warm_up                                      valid/ready
// rsp_chan  source  raw_value, window_mean, window_median, smoothed      valid/ready
// csr       write   csr_index, csr_write_data                            csr_write_enable
//
// One request is accepted per cycle while stage p0 is free. A result passes through
// stages p0 and p1 into the output register, and a stall can hold it in any of them.
// The window cells and the smoother hold the state; one request a cycle is set by the
// smoother's single multiply-add loop.
// Reset is synchronous and active high; it clears the window, the smoother and the pipe.
// A stalled result backs up the pipe; a request is taken while any stage is free.
module sensor_filter_bank #(
   parameter int WINDOW = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   sfb_req_if.sink                req_chan,
   sfb_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  sfb_pkg::csr_index_type csr_index,
   input  sfb_pkg::weight_type    csr_write_data
);
   import sfb_pkg::*;

   // Widths of the window sum and of the constant divide. The divide uses a
   // rounded-up reciprocal with enough fraction bits to be exact for every
   // sum magnitude, so no correction step follows the multiply.
   localparam int CW        = $clog2(WINDOW);
   localparam int SUM_W     = SAMPLE_W + CW;
   localparam int DIV_SHIFT = SUM_W + CW;
   localparam longint unsigned DIV_MULT =
      ((64'd1 << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);

   // Configuration registers. The weight is stored already saturated to one.
   weight_type weight_ff;
   weight_type weight_in;
   logic       enable_ff;
   logic       enable_in;

   always_comb begin
      weight_in = weight_ff;
      enable_in = enable_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SMOOTHING_WEIGHT: begin
               weight_in = (csr_write_data > WEIGHT_ONE) ? WEIGHT_ONE : csr_write_data;
            end
            CSR_STREAM_ENABLE: begin
               enable_in = csr_write_data[0];
            end
            default: begin
               weight_in = weight_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         enable_ff <= 1'b1;
      end else begin
         weight_ff <= weight_in;
         enable_ff <= enable_in;
      end
   end

   // Pipeline handshake. Stage p0 holds a request whose window is still in
   // the cells, so the cells may change only when p0 is free to advance.
   logic p0_valid_ff, p0_valid_in;
   logic p1_valid_ff, p1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, p1_free, p0_free;
   logic accept, emit;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign p1_free  = !p1_valid_ff || out_free;
   assign p0_free  = !p0_valid_ff || p1_free;

   assign req_chan.ready = p0_free;
   assign accept = req_chan.valid && p0_free;
   // A warm-up request updates state whatever streaming is set to; an
   // ordinary request with streaming off is dropped with no state change.
   assign emit   = !req_chan.warm_up && enable_ff;

   state_ctl_type upd_ctl;
   assign upd_ctl.fill  = accept && req_chan.warm_up;
   assign upd_ctl.shift = accept && emit;

   assign p0_valid_in  = accept ? emit : (p0_valid_ff && !p1_free);
   assign p1_valid_in  = p1_free ? p0_valid_ff : p1_valid_ff;
   assign out_valid_in = out_free ? p1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff  <= p0_valid_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Window: a chain of cells, the oldest sample in cell zero. On a shift
   // every cell takes its newer neighbor and the last cell takes the sample.
   sample_type cell_value [WINDOW];
   logic       cell_median [WINDOW];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      sample_type neighbor;
      if (i == WINDOW - 1) begin : g_last
         assign neighbor = req_chan.sample;
      end else begin : g_inner
         assign neighbor = cell_value[i + 1];
      end
      sfb_cell #(
         .WINDOW (WINDOW),
         .POS    (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (upd_ctl),
         .fill_value     (req_chan.sample),
         .neighbor_value (neighbor),
         .window         (cell_value),
         .value          (cell_value[i]),
         .is_median      (cell_median[i])
      );
   end

   state_type smoother_state;

   sfb_smoother u_smoother (
      .clock  (clock),
      .reset  (reset),
      .ctl    (upd_ctl),
      .sample (req_chan.sample),
      .weight (weight_ff),
      .state  (smoother_state)
   );

   // Stage p0: sum and median straight from the cells.
   sample_type              p0_raw_ff;
   logic signed [SUM_W-1:0] window_sum;
   sample_type              window_med;

   always_ff @(posedge clock) begin
      if (accept) begin
         p0_raw_ff <= req_chan.sample;
      end
   end

   always_comb begin
      window_sum = '0;
      window_med = '0;
      for (int i = 0; i < WINDOW; i++) begin
         window_sum = window_sum + SUM_W'(cell_value[i]);
         if (cell_median[i]) begin
            window_med = window_med | cell_value[i];
         end
      end
   end

   // Stage p1.
   sample_type              p1_raw_ff;
   sample_type              p1_smooth_ff;
   sample_type              p1_med_ff;
   logic signed [SUM_W-1:0] p1_sum_ff;

   always_ff @(posedge clock) begin
      if (p1_free && p0_valid_ff) begin
         p1_raw_ff    <= p0_raw_ff;
         p1_smooth_ff <= smoother_state[FRAC_W +: SAMPLE_W];
         p1_med_ff    <= window_med;
         p1_sum_ff    <= window_sum;
      end
   end

   // Mean: magnitude times the reciprocal, then the sign back, which gives
   // truncation toward zero.
   logic [SUM_W-1:0]           sum_mag;
   logic [DIV_SHIFT:0]         div_mult;
   logic [SUM_W+DIV_SHIFT:0]   div_prod;
   logic [SAMPLE_W-1:0]        mean_mag;
   sample_type                 mean_value;

   assign sum_mag    = p1_sum_ff[SUM_W-1] ? SUM_W'(-p1_sum_ff) : SUM_W'(p1_sum_ff);
   assign div_mult   = DIV_MULT[DIV_SHIFT:0];
   assign div_prod   = (SUM_W + DIV_SHIFT + 1)'(sum_mag) * (SUM_W + DIV_SHIFT + 1)'(div_mult);
   assign mean_mag   = div_prod[DIV_SHIFT +: SAMPLE_W];
   assign mean_value = p1_sum_ff[SUM_W-1] ? sample_type'(-mean_mag) : sample_type'(mean_mag);

   // Output register.
   sample_type out_raw_ff, out_mean_ff, out_med_ff, out_smooth_ff;

   always_ff @(posedge clock) begin
      if (out_free && p1_valid_ff) begin
         out_raw_ff    <= p1_raw_ff;
         out_mean_ff   <= mean_value;
         out_med_ff    <= p1_med_ff;
         out_smooth_ff <= p1_smooth_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.raw_value     = out_raw_ff;
   assign rsp_chan.window_mean   = out_mean_ff;
   assign rsp_chan.window_median = out_med_ff;
   assign rsp_chan.smoothed      = out_smooth_ff;

   // A warm-up request loads every cell and the smoother with its sample.
   a_warm_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.warm_up && !reset) |=>
         (cell_value[0] == $past(req_chan.sample))
         && (cell_value[WINDOW-1] == $past(req_chan.sample))
         && (smoother_state[FRAC_W +: SAMPLE_W] == $past(req_chan.sample)))
      else $error("warm-up did not preload the window and smoother");

   // A dropped request leaves the state untouched.
   a_drop_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.warm_up && !enable_ff && !reset) |=>
         ($stable(cell_value[0]) && $stable(cell_value[WINDOW-1])
          && $stable(smoother_state)))
      else $error("dropped request changed the filter state");

   // The window of a request waiting in p0 must not move under it.
   a_p0_hold: assert property (@(posedge clock) disable iff (reset)
      (p0_valid_ff && !p1_free && !reset) |=>
         ($stable(cell_value[WINDOW-1]) && $stable(smoother_state) && p0_valid_ff))
      else $error("window changed while its result was stalled");

   // Every streaming request reaches stage p0 on the next cycle.
   a_p0_load: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && !reset) |=> (p0_valid_ff && (p0_raw_ff == $past(req_chan.sample))))
      else $error("accepted request lost before stage p0");

endmodule

@@ dv/sensor_filter_bank_tb.sv @@
// Self-checking bench for the sensor filter bank. Each accepted request is
// replayed on a local copy of the filters, and every result the block returns
// is compared, field by field, against the oldest filtered value still due.
module sensor_filter_bank_tb;
   import sfb_pkg::*;

   localparam int WINDOW_LEN      = 5;
   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 4;
   // A result passes through stages p0 and p1 to the output register. Requests
   // that make no result change the state at the edge that takes them and never
   // enter the pipe. A register write still waits until the block is surely idle.
   localparam int DRAIN_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS    = 600;
   localparam int CYCLE_LIMIT     = 300000;

   // One result of the block, in port order.
   typedef struct packed {
      sample_type raw;
      sample_type mean;
      sample_type median;
      sample_type smooth;
   } filter_result_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_WRITE
   } row_kind_type;

   // One line of the directed plan: either a request or a register write. A request
   // row may carry a hand-written result. Such a result is used in place of the
   // predicted one.
   typedef struct packed {
      row_kind_type      kind;
      sample_type        sample;
      logic              warm_up;
      logic              typed;
      filter_result_type want;
      csr_index_type     index;
      weight_type        data;
   } plan_row_type;

   localparam filter_result_type NONE = '0;
   localparam int DIRECTED_ROWS = 28;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // Straight after reset the window and the smoother hold zero.
      '{ROW_REQUEST, 16'sd0, 1'b0, 1'b1, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      // Warm-up at both extremes. A matching sample then reads back unchanged
      // through every filter.
      '{ROW_REQUEST, 16'sh7FFF, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh7FFF, 1'b0, 1'b1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh8000, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh8000, 1'b0, 1'b1, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sd0, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh7FFF, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, -16'sd1, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      // A weight of one makes the smoother follow the sample exactly.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, WEIGHT_ONE},
      '{ROW_REQUEST, 16'sd0, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sd1000, 1'b0, 1'b1, '{16'sd1000, 16'sd200, 16'sd0, 16'sd1000},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      // A weight above one saturates to one.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'h1FFFF},
      '{ROW_REQUEST, 16'sd0, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, -16'sd1000, 1'b0, 1'b1, '{-16'sd1000, -16'sd200, 16'sd0, -16'sd1000},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      // A weight of zero freezes the smoother.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sd300, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, -16'sd300, 1'b0, 1'b1, '{-16'sd300, 16'sd180, 16'sd300, 16'sd300},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      // With streaming off, ordinary samples are dropped, but a warm-up still loads
      // the state.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_STREAM_ENABLE, 17'd0},
      '{ROW_REQUEST, 16'sd555, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sd777, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh8000, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      // Only bit zero of the write data counts for the enable.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_STREAM_ENABLE, 17'h1FFFF},
      '{ROW_REQUEST, 16'sd777, 1'b0, 1'b1, '{16'sd777, 16'sd777, 16'sd777, 16'sd777},
        CSR_SMOOTHING_WEIGHT, 17'd0},
      // Back at the reset weight. A small negative step must floor to minus one.
      '{ROW_WRITE, 16'sd0, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, WEIGHT_RESET},
      '{ROW_REQUEST, 16'sd0, 1'b1, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, -16'sd1, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh7FFF, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0},
      '{ROW_REQUEST, 16'sh8000, 1'b0, 1'b0, NONE, CSR_SMOOTHING_WEIGHT, 17'd0}
   };

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   weight_type    csr_write_data;

   sfb_req_if req_bus();
   sfb_rsp_if rsp_bus();

   sensor_filter_bank #(
      .WINDOW(WINDOW_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // This is the local copy of the filter state. It is updated only at edges where a
   // request or a register write is taken.
   sample_type recent_samples [WINDOW_LEN];
   state_type  lowpass_q16;
   weight_type lowpass_weight;
   logic       streaming_on;

   filter_result_type filtered_due [$];
   int                error_count;
   int                cycle_count;

   // Shared controls of the stimulus. A hand-written result travels with its
   // request. It is driven together with the payload, so the observer sees both
   // at the same edge.
   logic              typed_row;
   filter_result_type typed_result;
   logic              steady;
   logic              in_random;
   logic              held_off;

   initial begin
      clock = 1'b0;
   end

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // This runs the bank on one sample. The call returns 1 when the sample makes a
   // result, and the result is written to r.
   function automatic logic filter_sample(input sample_type v, input logic warm,
                                          output filter_result_type r);
      int         total;
      int         j;
      sample_type sorted [WINDOW_LEN];
      sample_type key;
      longint     w;
      longint     acc;
      r = '0;
      if (warm) begin
         foreach (recent_samples[i]) recent_samples[i] = v;
         lowpass_q16 = state_type'(longint'(v) * 65536);
         return 1'b0;
      end
      if (!streaming_on) begin
         return 1'b0;
      end
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
         recent_samples[i] = recent_samples[i + 1];
      end
      recent_samples[WINDOW_LEN - 1] = v;

      // The sum is at most five full-scale samples, so an int holds it. The SV
      // division truncates toward zero, as the mean requires.
      total = 0;
      foreach (recent_samples[i]) total += recent_samples[i];

      sorted = recent_samples;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end

      // The smoother is computed exactly in 64 bits. The arithmetic shift then
      // rounds toward minus infinity.
      w = (lowpass_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(lowpass_weight);
      acc = w * (longint'(v) * 65536) + (65536 - w) * longint'(lowpass_q16);
      lowpass_q16 = state_type'(acc >>> FRAC_W);

      r.raw    = v;
      r.mean   = sample_type'(total / WINDOW_LEN);
      r.median = sorted[WINDOW_LEN / 2];
      r.smooth = sample_type'(lowpass_q16 >>> FRAC_W);
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input sample_type want,
                              input sample_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Everything is sampled at the rising edge, before the nonblocking updates of
   // that edge. So this block sees exactly what the block under test sees.
   always @(posedge clock) begin : observe
      filter_result_type predicted;
      filter_result_type seen;
      filter_result_type due;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SMOOTHING_WEIGHT: lowpass_weight = csr_write_data;
               CSR_STREAM_ENABLE:    streaming_on = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (filter_sample(req_bus.sample, req_bus.warm_up, predicted)) begin
               filtered_due.push_back(typed_row ? typed_result : predicted);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{rsp_bus.raw_value, rsp_bus.window_mean, rsp_bus.window_median,
                     rsp_bus.smoothed};
            if (filtered_due.size() == 0) begin
               $error("result with none due: raw_value %0d", seen.raw);
               error_count++;
            end else begin
               due = filtered_due.pop_front();
               check_field("raw_value", due.raw, seen.raw);
               check_field("window_mean", due.mean, seen.mean);
               check_field("window_median", due.median, seen.median);
               check_field("smoothed", due.smooth, seen.smooth);
            end
         end
      end
   end

   // Some samples are full-scale, some are close to zero, and most are anywhere in
   // the range.
   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return sample_type'(int'($urandom_range(40)) - 20);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // This offers one request and returns at the edge that takes it. Any idle gap
   // comes first. In that case valid drops for the gap and rises again later, so
   // valid never gets two assignments in one time step.
   task automatic offer_request(input sample_type s, input logic warm, input logic typed,
                                input filter_result_type want);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 18) gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= s;
      req_bus.warm_up <= warm;
      typed_row       <= typed;
      typed_result    <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Registers change only while the block is idle. The task first waits for every
   // due result, then waits out the drain time before it writes.
   task automatic write_register(input csr_index_type which, input weight_type value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The receiver is ready most of the time. Once, early in the random part, it
   // holds off for a long stretch while requests keep coming. The pipe then fills
   // and the block must stall its input.
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held_off && in_random && filtered_due.size() >= 2) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 18);
            @(posedge clock);
         end
      end
   end

   // The watchdog counts cycles. If the limit is reached, the run fails.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sensor_filter_bank_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int         phase;
      int         effective;
      int         batch;
      logic       enable;
      weight_type weight;

      // The local filter state starts at its reset values.
      foreach (recent_samples[i]) recent_samples[i] = '0;
      lowpass_q16    = '0;
      lowpass_weight = WEIGHT_RESET;
      streaming_on   = 1'b1;
      error_count    = 0;
      steady         = 1'b0;
      in_random      = 1'b0;
      held_off       = 1'b0;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SMOOTHING_WEIGHT;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.sample   <= '0;
      req_bus.warm_up  <= 1'b0;
      typed_row        <= 1'b0;
      typed_result     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The directed plan covers the extremes, every special case of the filters,
      // and each register.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
            write_register(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].data);
         end else begin
            offer_request(DIRECTED_PLAN[i].sample, DIRECTED_PLAN[i].warm_up,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      // The random part runs in phases. Each phase starts with a new setting of both
      // registers. Most phases stream, and a short phase with streaming off now and
      // then checks that samples are dropped. Dropped samples do not count toward
      // the item total. Two phases run without idling on either side.
      in_random = 1'b1;
      phase = 0;
      effective = 0;
      while (effective < RANDOM_ITEMS) begin
         case ($urandom_range(7))
            0:       weight = '0;
            1:       weight = WEIGHT_ONE;
            2:       weight = 17'd1;
            3:       weight = 17'd65535;
            4:       weight = weight_type'($urandom_range(131071, 65537));
            5:       weight = WEIGHT_RESET;
            default: weight = weight_type'($urandom_range(65536));
         endcase
         write_register(CSR_SMOOTHING_WEIGHT, weight);
         enable = (phase == 0) || ($urandom_range(5) != 0);
         write_register(CSR_STREAM_ENABLE, weight_type'({16'($urandom_range(65535)), enable}));

         steady = (phase == 3 || phase == 4);
         batch = enable ? 50 : 12;
         repeat (batch) begin
            offer_request(pick_sample(), $urandom_range(19) == 0, 1'b0, NONE);
         end
         if (enable) begin
            effective += batch;
         end
         phase++;
      end
      steady = 1'b0;

      // Wait for the due results to come back, then allow a short tail. Any stray
      // result in the tail still gets flagged.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && filtered_due.size() == 0) begin
         $display("sensor_filter_bank_tb: done, clean");
      end else begin
         $display("sensor_filter_bank_tb: done, errors");
      end
      $finish;
   end

endmodule
